FILE: src/jpfv_pkg.sv
// jpfv_pkg: types, widths and codes shared by the joint pid filtered velocity block
// no dependencies; used by jpfv_div, jpfv_mul and joint_pid_filtered_velocity
package jpfv_pkg;

  // binary angles, full turn is 2**ANGLE_BITS
  localparam int ANGLE_BITS  = 16;
  // velocity is kept in angle units per 1024 us
  localparam int VEL_SHIFT   = 10;
  localparam int DIVIDEND_W  = ANGLE_BITS + VEL_SHIFT;
  localparam int DIVISOR_W   = 16;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);
  localparam int VN_W        = DIVIDEND_W + 1;

  // shared multiplier operand and product widths
  localparam int MUL_A_W     = 17;
  localparam int MUL_B_W     = 33;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int ACC_W       = PROD_W;

  localparam int GAIN_W      = 16;
  localparam int SMOOTH_W    = 9;
  localparam int LIMIT_W     = 31;
  localparam int VEL_W       = 32;
  localparam int INTEG_W     = 32;
  localparam int ISUM_W      = 35;
  localparam int INTEG_SHIFT = 20;
  localparam int TORQUE_SHIFT = 8;
  localparam int DRIVE_W     = 16;

  localparam logic [SMOOTH_W-1:0] SMOOTH_ONE = 9'd256;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PROP_GAIN      = 3'd0,
    CFG_DERIV_GAIN     = 3'd1,
    CFG_INTEG_GAIN     = 3'd2,
    CFG_VEL_SMOOTHING  = 3'd3,
    CFG_INTEGRAL_LIMIT = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_VN,
    ST_MUL_W,
    ST_MUL_WO,
    ST_VSUM,
    ST_VFIX,
    ST_VE,
    ST_IADD,
    ST_ICLAMP,
    ST_KD,
    ST_KI,
    ST_DRIVE
  } state_t;

  typedef struct packed {
    logic [1:0]            joint;
    logic [ANGLE_BITS-1:0] angle_measured;
    logic [ANGLE_BITS-1:0] angle_target;
    logic [15:0]           elapsed_us;
  } sample_t;

  typedef struct packed {
    logic [1:0]                joint_out;
    logic signed [DRIVE_W-1:0] drive;
    logic signed [15:0]        position_error;
    logic signed [VEL_W-1:0]   velocity_error;
    logic                      saturated;
  } result_t;

endpackage

FILE: src/joint_pid_filtered_velocity.sv
// joint_pid_filtered_velocity: per-joint pid with smoothed velocity and clamped integral
// depends on jpfv_pkg, jpfv_div (velocity divide) and jpfv_mul (shared multiplier)
//
//   channel  | signals                            | direction | handshake
//   ---------+------------------------------------+-----------+-------------------------
//   sample   | sample_valid, sample_stall, sample | in        | transaction: valid & !stall
//   result   | result_valid, result_stall, result | out       | transaction: valid & !stall
//   config   | cfg_valid, cfg_ready, cfg_index,   | in        | write: valid & ready
//            | cfg_data                           |           |
//
// an item passes through the idle state that takes the sample, a load step, the serial
// divider (one quotient bit a cycle over the 26-bit scaled angle step) and eleven
// sequencer steps for the blend, integral clamp and gain sums, six of which feed the
// shared multiplier
// the result sits in an output register; the next sample is taken as soon as the sequencer
// is idle, and only the final write waits if the previous result is still stalled
// rst is synchronous and restores the register defaults and clears all joint state
// samples for a joint number at or above JOINT_COUNT are taken and dropped without a result
module joint_pid_filtered_velocity #(
  parameter int JOINT_COUNT = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  jpfv_pkg::sample_t                   sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output jpfv_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jpfv_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [jpfv_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int JIDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int AB     = jpfv_pkg::ANGLE_BITS;
  localparam int ACC_W  = jpfv_pkg::ACC_W;
  localparam int VEL_W  = jpfv_pkg::VEL_W;
  localparam int ISUM_W = jpfv_pkg::ISUM_W;

  // saturation bounds, in accumulator, velocity and drive widths
  localparam logic signed [ACC_W-1:0] VEL_HI =
    {{(ACC_W-VEL_W+1){1'b0}}, {(VEL_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] VEL_LO = ~VEL_HI;
  localparam logic signed [ACC_W-1:0] T_LO   = -ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] T_HI   = ACC_W'(32768);
  localparam logic signed [VEL_W-1:0] V32_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] V32_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic signed [jpfv_pkg::DRIVE_W-1:0] DRV_MAX =
    {1'b0, {(jpfv_pkg::DRIVE_W-1){1'b1}}};
  localparam logic signed [jpfv_pkg::DRIVE_W-1:0] DRV_MIN =
    {1'b1, {(jpfv_pkg::DRIVE_W-1){1'b0}}};

  jpfv_pkg::state_t state, state_next;

  // configuration registers
  logic signed [jpfv_pkg::GAIN_W-1:0]  prop_gain;
  logic signed [jpfv_pkg::GAIN_W-1:0]  deriv_gain;
  logic signed [jpfv_pkg::GAIN_W-1:0]  integ_gain;
  logic [jpfv_pkg::SMOOTH_W-1:0]       vel_smoothing;
  logic [jpfv_pkg::LIMIT_W-1:0]        integral_limit;

  // per-joint state
  logic [AB-1:0]                       last_angle     [JOINT_COUNT];
  logic signed [VEL_W-1:0]             smooth_vel     [JOINT_COUNT];
  logic signed [jpfv_pkg::INTEG_W-1:0] err_integ      [JOINT_COUNT];

  // working registers for the item in flight
  logic [JIDX_W-1:0]                   jsel;
  logic [1:0]                          jnum;
  logic [AB-1:0]                       meas;
  logic [AB-1:0]                       targ;
  logic [15:0]                         dt;
  logic signed [AB-1:0]                e;
  logic                                dneg;
  logic signed [jpfv_pkg::VN_W-1:0]    vn;
  logic signed [ACC_W-1:0]             acc;
  logic signed [VEL_W-1:0]             v;
  logic signed [VEL_W-1:0]             ve;
  logic signed [ISUM_W-1:0]            isum;
  logic signed [jpfv_pkg::INTEG_W-1:0] integ;
  logic                                sat_i;

  // control and datapath nets
  logic                                accept;
  logic                                joint_ok;
  logic                                res_load;
  logic                                div_start;
  logic                                div_busy;
  logic [jpfv_pkg::DIVIDEND_W-1:0]     div_q;
  logic [AB-1:0]                       dth;
  logic [AB-1:0]                       dmag;
  logic [jpfv_pkg::SMOOTH_W-1:0]       w_eff;
  logic [jpfv_pkg::SMOOTH_W-1:0]       w_old;
  logic signed [jpfv_pkg::MUL_A_W-1:0] mul_a;
  logic signed [jpfv_pkg::MUL_B_W-1:0] mul_b;
  logic signed [jpfv_pkg::PROD_W-1:0]  prod;
  logic signed [VEL_W-1:0]             vold;
  logic signed [jpfv_pkg::INTEG_W-1:0] integ_old;
  logic signed [ACC_W-1:0]             vround;
  logic signed [ACC_W-1:0]             vq;
  logic signed [VEL_W-1:0]             vsat;
  logic signed [ISUM_W-1:0]            lim_pos;
  logic signed [ISUM_W-1:0]            lim_neg;
  logic signed [ISUM_W-1:0]            psum;
  logic signed [ACC_W-1:0]             t;
  logic signed [ACC_W-1:0]             tneg;
  logic signed [jpfv_pkg::DRIVE_W-1:0] drive_val;
  logic                                sat_d;

  assign cfg_ready = 1'b1;
  assign accept    = sample_valid && !sample_stall;
  assign joint_ok  = {30'd0, sample.joint} < 32'(JOINT_COUNT);

  // shared units
  jpfv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({dmag, {jpfv_pkg::VEL_SHIFT{1'b0}}}),
    .divisor  (dt),
    .busy     (div_busy),
    .quotient (div_q)
  );

  jpfv_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jpfv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      jpfv_pkg::ST_IDLE:   if (sample_valid && joint_ok) state_next = jpfv_pkg::ST_LOAD;
      jpfv_pkg::ST_LOAD:   state_next = jpfv_pkg::ST_DIV;
      jpfv_pkg::ST_DIV:    if (!div_busy) state_next = jpfv_pkg::ST_VN;
      jpfv_pkg::ST_VN:     state_next = jpfv_pkg::ST_MUL_W;
      jpfv_pkg::ST_MUL_W:  state_next = jpfv_pkg::ST_MUL_WO;
      jpfv_pkg::ST_MUL_WO: state_next = jpfv_pkg::ST_VSUM;
      jpfv_pkg::ST_VSUM:   state_next = jpfv_pkg::ST_VFIX;
      jpfv_pkg::ST_VFIX:   state_next = jpfv_pkg::ST_VE;
      jpfv_pkg::ST_VE:     state_next = jpfv_pkg::ST_IADD;
      jpfv_pkg::ST_IADD:   state_next = jpfv_pkg::ST_ICLAMP;
      jpfv_pkg::ST_ICLAMP: state_next = jpfv_pkg::ST_KD;
      jpfv_pkg::ST_KD:     state_next = jpfv_pkg::ST_KI;
      jpfv_pkg::ST_KI:     state_next = jpfv_pkg::ST_DRIVE;
      jpfv_pkg::ST_DRIVE:  if (res_load) state_next = jpfv_pkg::ST_IDLE;
      default:             state_next = jpfv_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, divider start and multiplier operands
  always_comb begin
    sample_stall = state != jpfv_pkg::ST_IDLE;
    div_start    = state == jpfv_pkg::ST_LOAD;
    res_load     = (state == jpfv_pkg::ST_DRIVE) && (!result_valid || !result_stall);
    mul_a        = '0;
    mul_b        = '0;
    unique case (state)
      jpfv_pkg::ST_MUL_W: begin
        mul_a = {{(jpfv_pkg::MUL_A_W-jpfv_pkg::SMOOTH_W){1'b0}}, w_eff};
        mul_b = {{(jpfv_pkg::MUL_B_W-jpfv_pkg::VN_W){vn[jpfv_pkg::VN_W-1]}}, vn};
      end
      jpfv_pkg::ST_MUL_WO: begin
        mul_a = {{(jpfv_pkg::MUL_A_W-jpfv_pkg::SMOOTH_W){1'b0}}, w_old};
        mul_b = {{(jpfv_pkg::MUL_B_W-VEL_W){vold[VEL_W-1]}}, vold};
      end
      jpfv_pkg::ST_VE: begin
        mul_a = {{(jpfv_pkg::MUL_A_W-16){1'b0}}, dt};
        mul_b = {{(jpfv_pkg::MUL_B_W-AB){e[AB-1]}}, e};
      end
      jpfv_pkg::ST_IADD: begin
        mul_a = {{(jpfv_pkg::MUL_A_W-jpfv_pkg::GAIN_W){prop_gain[jpfv_pkg::GAIN_W-1]}},
                 prop_gain};
        mul_b = {{(jpfv_pkg::MUL_B_W-AB){e[AB-1]}}, e};
      end
      jpfv_pkg::ST_ICLAMP: begin
        mul_a = {{(jpfv_pkg::MUL_A_W-jpfv_pkg::GAIN_W){deriv_gain[jpfv_pkg::GAIN_W-1]}},
                 deriv_gain};
        mul_b = {{(jpfv_pkg::MUL_B_W-VEL_W){ve[VEL_W-1]}}, ve};
      end
      jpfv_pkg::ST_KD: begin
        mul_a = {{(jpfv_pkg::MUL_A_W-jpfv_pkg::GAIN_W){integ_gain[jpfv_pkg::GAIN_W-1]}},
                 integ_gain};
        mul_b = {{(jpfv_pkg::MUL_B_W-jpfv_pkg::INTEG_W){integ[jpfv_pkg::INTEG_W-1]}}, integ};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // combinational helpers
  assign w_eff     = (vel_smoothing > jpfv_pkg::SMOOTH_ONE) ? jpfv_pkg::SMOOTH_ONE
                                                           : vel_smoothing;
  assign w_old     = jpfv_pkg::SMOOTH_ONE - w_eff;
  assign vold      = smooth_vel[jsel];
  assign integ_old = err_integ[jsel];

  // wrapped angle step since the previous sample, as sign and magnitude
  assign dth  = meas - last_angle[jsel];
  assign dmag = dth[AB-1] ? (AB'(0) - dth) : dth;

  // blend divided by 256, truncated toward zero, then held to 32 bits
  assign vround = acc + (acc[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
  assign vq     = vround >>> jpfv_pkg::TORQUE_SHIFT;
  assign vsat   = (vq > VEL_HI) ? V32_MAX
                : (vq < VEL_LO) ? V32_MIN
                : vq[VEL_W-1:0];

  // integral clamp bounds
  assign lim_pos = {{(ISUM_W-jpfv_pkg::LIMIT_W){1'b0}}, integral_limit};
  assign lim_neg = -lim_pos;
  assign psum    = {{(ISUM_W-34){prod[33]}}, prod[33:0]};

  // torque is the floor of the sum over 256; drive is its negation, saturated
  assign t    = acc >>> jpfv_pkg::TORQUE_SHIFT;
  assign tneg = -t;
  always_comb begin
    sat_d     = 1'b0;
    drive_val = tneg[jpfv_pkg::DRIVE_W-1:0];
    priority if (t < T_LO) begin
      drive_val = DRV_MAX;
      sat_d     = 1'b1;
    end else if (t > T_HI) begin
      drive_val = DRV_MIN;
      sat_d     = 1'b1;
    end else begin
      drive_val = tneg[jpfv_pkg::DRIVE_W-1:0];
    end
  end

  // datapath registers, stepped by the sequencer
  always_ff @(posedge clk) begin
    unique case (state)
      jpfv_pkg::ST_IDLE: begin
        if (accept) begin
          jsel <= JIDX_W'(sample.joint);
          jnum <= sample.joint;
          meas <= sample.angle_measured;
          targ <= sample.angle_target;
          dt   <= (sample.elapsed_us == 16'd0) ? 16'd1 : sample.elapsed_us;
        end
      end
      jpfv_pkg::ST_LOAD: begin
        e    <= targ - meas;
        dneg <= dth[AB-1];
      end
      jpfv_pkg::ST_VN: begin
        vn <= dneg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
      end
      jpfv_pkg::ST_MUL_WO: acc <= prod;
      jpfv_pkg::ST_VSUM:   acc <= acc + prod;
      jpfv_pkg::ST_VFIX:   v <= vsat;
      jpfv_pkg::ST_VE:     ve <= (v == V32_MIN) ? V32_MAX : -v;
      jpfv_pkg::ST_IADD: begin
        isum <= {{(ISUM_W-jpfv_pkg::INTEG_W){integ_old[jpfv_pkg::INTEG_W-1]}}, integ_old}
                + psum;
      end
      jpfv_pkg::ST_ICLAMP: begin
        acc <= prod;
        priority if (isum > lim_pos) begin
          integ <= lim_pos[jpfv_pkg::INTEG_W-1:0];
          sat_i <= 1'b1;
        end else if (isum < lim_neg) begin
          integ <= lim_neg[jpfv_pkg::INTEG_W-1:0];
          sat_i <= 1'b1;
        end else begin
          integ <= isum[jpfv_pkg::INTEG_W-1:0];
          sat_i <= 1'b0;
        end
      end
      jpfv_pkg::ST_KD: acc <= acc + prod;
      jpfv_pkg::ST_KI: acc <= acc + (prod >>> jpfv_pkg::INTEG_SHIFT);
      default: begin
      end
    endcase
  end

  // per-joint state, written once the result is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINT_COUNT; i++) begin
        last_angle[i] <= '0;
        smooth_vel[i] <= '0;
        err_integ[i]  <= '0;
      end
    end else if (res_load) begin
      last_angle[jsel] <= meas;
      smooth_vel[jsel] <= v;
      err_integ[jsel]  <= integ;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.joint_out      <= jnum;
      result.drive          <= drive_val;
      result.position_error <= e;
      result.velocity_error <= ve;
      result.saturated      <= sat_i | sat_d;
    end
  end

  // configuration writes, unknown indices dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= '0;
      deriv_gain     <= '0;
      integ_gain     <= '0;
      vel_smoothing  <= jpfv_pkg::SMOOTH_ONE;
      integral_limit <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (jpfv_pkg::cfg_reg_t'(cfg_index))
        jpfv_pkg::CFG_PROP_GAIN:      prop_gain      <= cfg_data[jpfv_pkg::GAIN_W-1:0];
        jpfv_pkg::CFG_DERIV_GAIN:     deriv_gain     <= cfg_data[jpfv_pkg::GAIN_W-1:0];
        jpfv_pkg::CFG_INTEG_GAIN:     integ_gain     <= cfg_data[jpfv_pkg::GAIN_W-1:0];
        jpfv_pkg::CFG_VEL_SMOOTHING:  vel_smoothing  <= cfg_data[jpfv_pkg::SMOOTH_W-1:0];
        jpfv_pkg::CFG_INTEGRAL_LIMIT: integral_limit <= cfg_data[jpfv_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: src/jpfv_div.sv
// jpfv_div: restoring shift-subtract divider, one quotient bit per cycle
// depends on jpfv_pkg for operand widths
module jpfv_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [jpfv_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [jpfv_pkg::DIVISOR_W-1:0]   divisor,
  output logic                             busy,
  output logic [jpfv_pkg::DIVIDEND_W-1:0]  quotient
);

  logic [jpfv_pkg::DIVISOR_W-1:0]  rem;
  logic [jpfv_pkg::DIVIDEND_W-1:0] quo;
  logic [jpfv_pkg::DIV_CNT_W-1:0]  cnt;
  logic [jpfv_pkg::DIVISOR_W:0]    trial;
  logic [jpfv_pkg::DIVISOR_W:0]    diff;
  logic                            fits;

  assign trial = {rem, quo[jpfv_pkg::DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};
  assign busy  = cnt != '0;
  assign quotient = quo;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= jpfv_pkg::DIV_CNT_W'(jpfv_pkg::DIVIDEND_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[jpfv_pkg::DIVISOR_W-1:0];
        quo <= {quo[jpfv_pkg::DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= trial[jpfv_pkg::DIVISOR_W-1:0];
        quo <= {quo[jpfv_pkg::DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: src/jpfv_mul.sv
// jpfv_mul: shared signed multiplier with registered product
// depends on jpfv_pkg for operand and product widths
module jpfv_mul (
  input  logic                               clk,
  input  logic signed [jpfv_pkg::MUL_A_W-1:0] a,
  input  logic signed [jpfv_pkg::MUL_B_W-1:0] b,
  output logic signed [jpfv_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
